[hdl/bpt_pkg.sv]
`default_nettype none

package bpt_pkg;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int MAG_W   = PROD_W;
   localparam int FRAC_W  = 16;
   localparam int DQ_W    = MAG_W + FRAC_W;
   localparam int Q_W     = DQ_W + 1;
   localparam int Q3_W    = Q_W + 2;
   localparam int W_W     = 24;

   localparam logic signed [Q3_W-1:0] ONE_Q16 = Q3_W'(65536);
   localparam logic signed [Q3_W-1:0] W_MAX   = Q3_W'(8388607);
   localparam logic signed [Q3_W-1:0] W_MIN   = -Q3_W'(8388608);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } bpt_vec_type;

   typedef struct packed {
      bpt_vec_type a;
      bpt_vec_type b;
      bpt_vec_type c;
      bpt_vec_type p;
   } bpt_tri_type;

   typedef struct packed {
      logic [DQ_W-1:0]  dq1;
      logic [DQ_W-1:0]  dq2;
      logic [MAG_W-1:0] rem1;
      logic [MAG_W-1:0] rem2;
      logic [MAG_W-1:0] dvs;
      logic             neg1;
      logic             neg2;
      logic             deg;
   } bpt_div_type;

   function automatic logic signed [DIFF_W-1:0] dif17(input logic signed [COORD_W-1:0] hi,
                                                     input logic signed [COORD_W-1:0] lo);
      return $signed({hi[COORD_W-1], hi}) - $signed({lo[COORD_W-1], lo});
   endfunction

   function automatic logic [W_W-1:0] sat24(input logic signed [Q3_W-1:0] v);
      if (v > W_MAX) begin
         return {1'b0, {(W_W-1){1'b1}}};
      end else if (v < W_MIN) begin
         return {1'b1, {(W_W-1){1'b0}}};
      end else begin
         return v[W_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

[hdl/bpt_setup.sv]
`default_nettype none

module bpt_setup
   import bpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_vld,
   input  wire logic [12*COORD_W-1:0] in_data,
   output logic                      in_rdy,
   output logic                      out_vld,
   output bpt_div_type               out_tok,
   input  wire logic                 out_rdy
);

   typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_type;

   function automatic logic signed [COORD_W-1:0] pick(input bpt_vec_type v, input axis_type ax);
      case (ax)
         AXIS_X:  return v.x;
         AXIS_Y:  return v.y;
         AXIS_Z:  return v.z;
         default: return v.x;
      endcase
   endfunction

   logic [5:0] vld_ff;
   logic [6:0] rdy;

   bpt_tri_type tri_in, tri1_ff, tri2_ff, tri3_ff;
   logic signed [DIFF_W-1:0] e_in[6];
   logic signed [DIFF_W-1:0] e_ff[6];
   logic signed [PROD_W-1:0] pr_ff[6];
   logic [MAG_W-1:0] ax_in, ay_in, az_in, ax_ff, ay_ff, az_ff;
   logic signed [SUM_W-1:0] n_x, n_y, n_z;
   axis_type u_ax, v_ax;
   logic signed [DIFF_W-1:0] d_in[8];
   logic signed [DIFF_W-1:0] d_ff[8];
   logic signed [PROD_W-1:0] m_ff[6];
   logic signed [SUM_W-1:0] den, num1, num2;
   bpt_div_type tok_in, tok_ff;

   always_comb begin
      rdy[6] = out_rdy;
      for (int k = 5; k >= 0; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
   end

   assign in_rdy  = rdy[0];
   assign out_vld = vld_ff[5];
   assign out_tok = tok_ff;

   always_comb begin
      tri_in.a.x = in_data[0*COORD_W +: COORD_W];
      tri_in.a.y = in_data[1*COORD_W +: COORD_W];
      tri_in.a.z = in_data[2*COORD_W +: COORD_W];
      tri_in.b.x = in_data[3*COORD_W +: COORD_W];
      tri_in.b.y = in_data[4*COORD_W +: COORD_W];
      tri_in.b.z = in_data[5*COORD_W +: COORD_W];
      tri_in.c.x = in_data[6*COORD_W +: COORD_W];
      tri_in.c.y = in_data[7*COORD_W +: COORD_W];
      tri_in.c.z = in_data[8*COORD_W +: COORD_W];
      tri_in.p.x = in_data[9*COORD_W +: COORD_W];
      tri_in.p.y = in_data[10*COORD_W +: COORD_W];
      tri_in.p.z = in_data[11*COORD_W +: COORD_W];
      e_in[0] = dif17(tri_in.b.x, tri_in.a.x);
      e_in[1] = dif17(tri_in.b.y, tri_in.a.y);
      e_in[2] = dif17(tri_in.b.z, tri_in.a.z);
      e_in[3] = dif17(tri_in.c.x, tri_in.b.x);
      e_in[4] = dif17(tri_in.c.y, tri_in.b.y);
      e_in[5] = dif17(tri_in.c.z, tri_in.b.z);
   end

   always_comb begin
      n_x = $signed({pr_ff[0][PROD_W-1], pr_ff[0]}) - $signed({pr_ff[1][PROD_W-1], pr_ff[1]});
      n_y = $signed({pr_ff[2][PROD_W-1], pr_ff[2]}) - $signed({pr_ff[3][PROD_W-1], pr_ff[3]});
      n_z = $signed({pr_ff[4][PROD_W-1], pr_ff[4]}) - $signed({pr_ff[5][PROD_W-1], pr_ff[5]});
      ax_in = n_x[SUM_W-1] ? MAG_W'(-n_x) : MAG_W'(n_x);
      ay_in = n_y[SUM_W-1] ? MAG_W'(-n_y) : MAG_W'(n_y);
      az_in = n_z[SUM_W-1] ? MAG_W'(-n_z) : MAG_W'(n_z);
   end

   always_comb begin
      if (ax_ff >= ay_ff && ax_ff >= az_ff) begin
         u_ax = AXIS_Y;
         v_ax = AXIS_Z;
      end else if (ay_ff >= az_ff) begin
         u_ax = AXIS_Z;
         v_ax = AXIS_X;
      end else begin
         u_ax = AXIS_X;
         v_ax = AXIS_Y;
      end
      d_in[0] = dif17(pick(tri3_ff.a, u_ax), pick(tri3_ff.c, u_ax));
      d_in[1] = dif17(pick(tri3_ff.a, v_ax), pick(tri3_ff.c, v_ax));
      d_in[2] = dif17(pick(tri3_ff.b, u_ax), pick(tri3_ff.c, u_ax));
      d_in[3] = dif17(pick(tri3_ff.b, v_ax), pick(tri3_ff.c, v_ax));
      d_in[4] = dif17(pick(tri3_ff.p, u_ax), pick(tri3_ff.a, u_ax));
      d_in[5] = dif17(pick(tri3_ff.p, v_ax), pick(tri3_ff.a, v_ax));
      d_in[6] = dif17(pick(tri3_ff.p, u_ax), pick(tri3_ff.c, u_ax));
      d_in[7] = dif17(pick(tri3_ff.p, v_ax), pick(tri3_ff.c, v_ax));
   end

   always_comb begin
      den  = $signed({m_ff[0][PROD_W-1], m_ff[0]}) - $signed({m_ff[1][PROD_W-1], m_ff[1]});
      num1 = $signed({m_ff[2][PROD_W-1], m_ff[2]}) - $signed({m_ff[3][PROD_W-1], m_ff[3]});
      num2 = $signed({m_ff[4][PROD_W-1], m_ff[4]}) - $signed({m_ff[5][PROD_W-1], m_ff[5]});
      tok_in.dq1  = {(num1[SUM_W-1] ? MAG_W'(-num1) : MAG_W'(num1)), FRAC_W'(0)};
      tok_in.dq2  = {(num2[SUM_W-1] ? MAG_W'(-num2) : MAG_W'(num2)), FRAC_W'(0)};
      tok_in.rem1 = '0;
      tok_in.rem2 = '0;
      tok_in.dvs  = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
      tok_in.neg1 = num1[SUM_W-1] ^ den[SUM_W-1];
      tok_in.neg2 = num2[SUM_W-1] ^ ~den[SUM_W-1];
      tok_in.deg  = (den == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= in_vld;
         end
         for (int k = 1; k < 6; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         tri1_ff <= tri_in;
         for (int i = 0; i < 6; i++) begin
            e_ff[i] <= e_in[i];
         end
      end
      if (rdy[1]) begin
         tri2_ff  <= tri1_ff;
         pr_ff[0] <= e_ff[1] * e_ff[5];
         pr_ff[1] <= e_ff[2] * e_ff[4];
         pr_ff[2] <= e_ff[2] * e_ff[3];
         pr_ff[3] <= e_ff[0] * e_ff[5];
         pr_ff[4] <= e_ff[0] * e_ff[4];
         pr_ff[5] <= e_ff[1] * e_ff[3];
      end
      if (rdy[2]) begin
         tri3_ff <= tri2_ff;
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         az_ff   <= az_in;
      end
      if (rdy[3]) begin
         for (int i = 0; i < 8; i++) begin
            d_ff[i] <= d_in[i];
         end
      end
      if (rdy[4]) begin
         m_ff[0] <= d_ff[1] * d_ff[2];
         m_ff[1] <= d_ff[3] * d_ff[0];
         m_ff[2] <= d_ff[7] * d_ff[2];
         m_ff[3] <= d_ff[3] * d_ff[6];
         m_ff[4] <= d_ff[5] * d_ff[0];
         m_ff[5] <= d_ff[1] * d_ff[4];
      end
      if (rdy[5]) begin
         tok_ff <= tok_in;
      end
   end

endmodule

`default_nettype wire

[hdl/bpt_div_cell.sv]
`default_nettype none

module bpt_div_cell
   import bpt_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  in_vld,
   input  wire bpt_div_type in_tok,
   output logic       rdy,
   output logic       out_vld,
   output bpt_div_type out_tok,
   input  wire logic  nxt_rdy
);

   logic        vld_ff;
   bpt_div_type tok_ff, tok_in;
   logic [MAG_W:0]   r1, r2;
   logic [MAG_W+1:0] t1, t2;

   always_comb begin
      r1 = {in_tok.rem1, in_tok.dq1[DQ_W-1]};
      r2 = {in_tok.rem2, in_tok.dq2[DQ_W-1]};
      t1 = {1'b0, r1} - {2'b00, in_tok.dvs};
      t2 = {1'b0, r2} - {2'b00, in_tok.dvs};
      tok_in      = in_tok;
      tok_in.rem1 = t1[MAG_W+1] ? r1[MAG_W-1:0] : t1[MAG_W-1:0];
      tok_in.rem2 = t2[MAG_W+1] ? r2[MAG_W-1:0] : t2[MAG_W-1:0];
      tok_in.dq1  = {in_tok.dq1[DQ_W-2:0], ~t1[MAG_W+1]};
      tok_in.dq2  = {in_tok.dq2[DQ_W-2:0], ~t2[MAG_W+1]};
   end

   assign rdy     = ~vld_ff | nxt_rdy;
   assign out_vld = vld_ff;
   assign out_tok = tok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (rdy) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy) begin
         tok_ff <= tok_in;
      end
   end

endmodule

`default_nettype wire

[hdl/bpt_tail.sv]
`default_nettype none

module bpt_tail
   import bpt_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  in_vld,
   input  wire bpt_div_type in_tok,
   output logic       in_rdy,
   output logic       out_vld,
   output logic [79:0] out_data,
   input  wire logic  out_rdy
);

   logic t1_vld_ff, o_vld_ff, rdy_o, rdy_t1;
   logic signed [Q_W-1:0] q1_in, q2_in, q1_ff, q2_ff;
   logic deg_ff;
   logic signed [Q3_W-1:0] q1x, q2x, q3;
   logic [W_W-1:0] w1, w2, w3;
   logic [79:0] data_ff, data_in;

   assign rdy_o    = ~o_vld_ff | out_rdy;
   assign rdy_t1   = ~t1_vld_ff | rdy_o;
   assign in_rdy   = rdy_t1;
   assign out_vld  = o_vld_ff;
   assign out_data = data_ff;

   always_comb begin
      q1_in = in_tok.neg1 ? -$signed({1'b0, in_tok.dq1}) : $signed({1'b0, in_tok.dq1});
      q2_in = in_tok.neg2 ? -$signed({1'b0, in_tok.dq2}) : $signed({1'b0, in_tok.dq2});
   end

   always_comb begin
      q1x = $signed({{2{q1_ff[Q_W-1]}}, q1_ff});
      q2x = $signed({{2{q2_ff[Q_W-1]}}, q2_ff});
      q3  = ONE_Q16 - q1x - q2x;
      w1  = deg_ff ? '0 : sat24(q1x);
      w2  = deg_ff ? '0 : sat24(q2x);
      w3  = deg_ff ? '0 : sat24(q3);
      data_in = {6'b0, deg_ff,
                 ~deg_ff & ~w1[W_W-1] & ~w2[W_W-1] & ~w3[W_W-1],
                 w3, w2, w1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         if (rdy_t1) begin
            t1_vld_ff <= in_vld;
         end
         if (rdy_o) begin
            o_vld_ff <= t1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_t1) begin
         q1_ff  <= q1_in;
         q2_ff  <= q2_in;
         deg_ff <= in_tok.deg;
      end
      if (rdy_o) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[hdl/barycentric_point_in_triangle_unit.sv]
// Channel   Direction  Ports                          Payload
// req       in         req_tvalid/tready/tdata[191:0] vertices v1, v2, v3 and query point
// rsp       out        rsp_tvalid/tready/tdata[79:0]  three weights, inside and degenerate
//
// One transfer is accepted per cycle unless a stalled output has filled the pipeline.
// The pipeline is made of six setup stages, a chain of 50 divider cells (one quotient
// bit per cell for both weights) and two output stages.
// Reset is synchronous and clears every stage valid bit.
// Each stage holds its own valid bit, so bubbles close up while the output stalls.

`default_nettype none

module barycentric_point_in_triangle_unit
   import bpt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, query_x, query_y, query_z
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // weight_first, weight_second, weight_third, inside_res, degenerate, zero fill
   output logic [79:0]       rsp_tdata
);

   logic        vld[DQ_W+1];
   logic        rdy[DQ_W+1];
   bpt_div_type tok[DQ_W+1];

   bpt_setup u_setup (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (req_tvalid),
      .in_data (req_tdata),
      .in_rdy  (req_tready),
      .out_vld (vld[0]),
      .out_tok (tok[0]),
      .out_rdy (rdy[0])
   );

   for (genvar k = 0; k < DQ_W; k++) begin : g_cell
      bpt_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .in_vld  (vld[k]),
         .in_tok  (tok[k]),
         .rdy     (rdy[k]),
         .out_vld (vld[k+1]),
         .out_tok (tok[k+1]),
         .nxt_rdy (rdy[k+1])
      );
   end

   bpt_tail u_tail (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld[DQ_W]),
      .in_tok   (tok[DQ_W]),
      .in_rdy   (rdy[DQ_W]),
      .out_vld  (rsp_tvalid),
      .out_data (rsp_tdata),
      .out_rdy  (rsp_tready)
   );

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[73] |-> rsp_tdata[72:0] == '0)
      else $error("degenerate result with nonzero weights or inside set");

   a_inside_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[72] |-> !rsp_tdata[23] && !rsp_tdata[47] && !rsp_tdata[71])
      else $error("inside set with a negative weight");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request side blocked while output is free");

endmodule

`default_nettype wire

[tb/sv/barycentric_point_in_triangle_unit_tb.sv]
`timescale 1ns / 100ps

module barycentric_point_in_triangle_unit_tb;
   import bpt_pkg::*;

   typedef struct packed {
      logic signed [23:0] w1;
      logic signed [23:0] w2;
      logic signed [23:0] w3;
      logic               in_tri;
      logic               degen;
   } weights_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [79:0]  rsp_tdata;

   logic [191:0] query_queue[$];
   weights_type  weights_expected[$];
   int           error_count;
   int           result_count;
   int           degenerate_count;
   int           inside_count;
   int           burst_left;
   int           gap_left;
   int           hold_off_left;
   bit           hold_off_done;
   bit           stim_done;
   bit           req_fire;

   barycentric_point_in_triangle_unit uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint coord(input logic [191:0] d, input int idx);
      logic signed [15:0] c;
      c = d[idx*16 +: 16];
      return longint'(c);
   endfunction

   function automatic longint clamp_weight(input longint v);
      if (v > 64'sd8388607) begin
         return 64'sd8388607;
      end else if (v < -64'sd8388608) begin
         return -64'sd8388608;
      end
      return v;
   endfunction

   function automatic weights_type predict_weights(input logic [191:0] d);
      longint a[3], b[3], c[3], p[3], e1[3], e2[3], n[3];
      longint ax, ay, az, den, num1, num2, q1, q2, q3;
      int u, v;
      weights_type r;
      for (int i = 0; i < 3; i++) begin
         a[i] = coord(d, i);
         b[i] = coord(d, 3 + i);
         c[i] = coord(d, 6 + i);
         p[i] = coord(d, 9 + i);
         e1[i] = b[i] - a[i];
         e2[i] = c[i] - b[i];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      ax = n[0] < 0 ? -n[0] : n[0];
      ay = n[1] < 0 ? -n[1] : n[1];
      az = n[2] < 0 ? -n[2] : n[2];
      if (ax >= ay && ax >= az) begin
         u = 1;
         v = 2;
      end else if (ay >= az) begin
         u = 2;
         v = 0;
      end else begin
         u = 0;
         v = 1;
      end
      den = (a[v] - c[v]) * (b[u] - c[u]) - (b[v] - c[v]) * (a[u] - c[u]);
      num1 = (p[v] - c[v]) * (b[u] - c[u]) - (b[v] - c[v]) * (p[u] - c[u]);
      num2 = (p[v] - a[v]) * (a[u] - c[u]) - (a[v] - c[v]) * (p[u] - a[u]);
      r = '0;
      if (den == 0) begin
         r.degen = 1'b1;
      end else begin
         q1 = (num1 * 65536) / den;
         q2 = (num2 * 65536) / (-den);
         q3 = 65536 - q1 - q2;
         r.w1 = 24'(clamp_weight(q1));
         r.w2 = 24'(clamp_weight(q2));
         r.w3 = 24'(clamp_weight(q3));
         r.in_tri = !r.w1[23] && !r.w2[23] && !r.w3[23];
      end
      return r;
   endfunction

   function automatic logic [191:0] pack_query(input logic [15:0] f[12]);
      logic [191:0] d;
      for (int i = 0; i < 12; i++) begin
         d[i*16 +: 16] = f[i];
      end
      return d;
   endfunction

   function automatic logic [15:0] random_coord(input int span);
      if (span == 0) begin
         return 16'($urandom);
      end
      return 16'($urandom_range(2 * span) - span);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Directed queries, then random triangles with a query near their vertices.
   initial begin
      logic [15:0] f[12];
      logic [15:0] edges[4];
      int span;
      edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 12; i++) f[i] = edges[(k + i) % 4];
         query_queue.push_back(pack_query(f));
         for (int i = 0; i < 12; i++) f[i] = edges[k];
         query_queue.push_back(pack_query(f));
      end
      // Triangle in xy, yz and zx planes, point inside and outside.
      for (int ax = 0; ax < 3; ax++) begin
         for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 12; i++) f[i] = 16'h0000;
            f[3 + ax] = 16'h0100;
            f[6 + (ax + 1) % 3] = 16'h0100;
            f[9 + ax] = k ? 16'h0200 : 16'h0040;
            f[9 + (ax + 1) % 3] = k ? 16'hff00 : 16'h0040;
            query_queue.push_back(pack_query(f));
         end
      end
      // Collinear triangle.
      for (int i = 0; i < 12; i++) f[i] = 16'(i % 3 == 0 ? i * 64 : 0);
      query_queue.push_back(pack_query(f));
      // Equal normal components, and tiny triangle with far point to saturate.
      f = '{16'h0100, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0, 0, 0};
      query_queue.push_back(pack_query(f));
      f = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 16'h7fff, 16'h8000, 0};
      query_queue.push_back(pack_query(f));
      f = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 16'h8000, 16'h7fff, 16'h7fff};
      query_queue.push_back(pack_query(f));
      for (int n = 0; n < 1400; n++) begin
         case ($urandom_range(3))
            0: span = 0;
            1: span = 16;
            default: span = 2048;
         endcase
         for (int i = 0; i < 9; i++) f[i] = random_coord(span);
         if ($urandom_range(9) == 0) begin
            for (int i = 0; i < 3; i++) f[6 + i] = f[3 + i];
         end
         for (int i = 0; i < 3; i++) begin
            f[9 + i] = f[$urandom_range(2) * 3 + i] + random_coord(span == 0 ? 2048 : span);
         end
         query_queue.push_back(pack_query(f));
      end
      stim_done = 1'b1;
   end

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      error_count = 0;
      result_count = 0;
      degenerate_count = 0;
      inside_count = 0;
      burst_left = 0;
      gap_left = 0;
      hold_off_left = 0;
      hold_off_done = 1'b0;
   end

   // Sender: bursts of transfers separated by random gaps.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            void'(query_queue.pop_front());
         end
         if (req_tvalid && !req_fire) begin
            // Hold the offered item until it is taken.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (query_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= query_queue[0];
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(40, 1);
               gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: its own stall pattern plus one long hold-off.
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_off_done && result_count == 200) begin
            hold_off_done <= 1'b1;
            hold_off_left <= 300;
            rsp_tready <= 1'b0;
         end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            rsp_tready <= 1'b0;
         end else if (result_count % 256 < 64) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(3) != 0);
         end
      end
   end

   always @(posedge clock) begin
      weights_type got, want;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            weights_expected.push_back(predict_weights(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.w1 = rsp_tdata[23:0];
            got.w2 = rsp_tdata[47:24];
            got.w3 = rsp_tdata[71:48];
            got.in_tri = rsp_tdata[72];
            got.degen = rsp_tdata[73];
            result_count++;
            if (weights_expected.size() == 0) begin
               report_mismatch("unexpected result transfer", 0, 0);
            end else begin
               want = weights_expected.pop_front();
               degenerate_count += want.degen;
               inside_count += want.in_tri;
               if (got.w1 !== want.w1) report_mismatch("weight_first", got.w1, want.w1);
               if (got.w2 !== want.w2) report_mismatch("weight_second", got.w2, want.w2);
               if (got.w3 !== want.w3) report_mismatch("weight_third", got.w3, want.w3);
               if (got.in_tri !== want.in_tri) begin
                  report_mismatch("inside_res", got.in_tri, want.in_tri);
               end
               if (got.degen !== want.degen) begin
                  report_mismatch("degenerate", got.degen, want.degen);
               end
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      wait (stim_done && query_queue.size() == 0 && !req_tvalid);
      wait (weights_expected.size() == 0);
      repeat (100) @(posedge clock);
      $display("Checked %0d results: %0d inside, %0d degenerate.", result_count,
               inside_count, degenerate_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding.", weights_expected.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

[barycentric_point_in_triangle_unit.f]
hdl/bpt_pkg.sv
hdl/bpt_setup.sv
hdl/bpt_div_cell.sv
hdl/bpt_tail.sv
hdl/barycentric_point_in_triangle_unit.sv
tb/sv/barycentric_point_in_triangle_unit_tb.sv
